@@ design/lr_pkg.sv @@
// Shared types, constants and helpers for the line rasterizer.
package lr_pkg;

  localparam int COORD_BITS = 12;
  localparam int ERR_BITS   = COORD_BITS + 1;
  localparam int COLOR_BITS = 16;

  // Operation codes on the command channel
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] delta_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;
  typedef logic        [COLOR_BITS-1:0] color_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // latch raw endpoints and colour
    logic setup;  // order endpoints, form deltas and error term
    logic step;   // emit a pixel and advance
  } lr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;   // cursor has reached the end of the line
  } lr_status_t;

  // Sign-extend a coordinate to error width
  function automatic err_t ext(input coord_t v);
    return err_t'({v[COORD_BITS-1], v});
  endfunction

  // Magnitude of a signed difference
  function automatic err_t mag(input err_t v);
    return v[ERR_BITS-1] ? -v : v;
  endfunction

endpackage

@@ design/lr_ctrl.sv @@
// Controller: sequences load, setup and pixel steps and owns the beat handshakes.
module lr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic               op,
  output logic               pix_valid,
  input  logic               pix_stall,
  output lr_pkg::lr_cmd_t    cmd,
  input  lr_pkg::lr_status_t status
);
  import lr_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_DRAW  = 2'd2;

  logic [1:0] state, state_next;
  logic       pix_valid_next;
  logic       accept;

  // Hold off while setting up, or while a pixel waits on a stalled receiver
  assign cmd_stall = (state == ST_SETUP) || (pix_valid && pix_stall);
  assign accept    = cmd_valid && !cmd_stall;

  // Next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    pix_valid_next = pix_valid && pix_stall;
    unique case (state)
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_DRAW;
      end
      ST_DRAW: begin
        if (accept && op == OP_STEP) begin
          cmd.step       = 1'b1;
          pix_valid_next = 1'b1;
          if (status.last) state_next = ST_IDLE;
        end
      end
      default: begin
      end
    endcase
    // a load replaces any line in progress
    if (accept && op == OP_LOAD) begin
      cmd.load   = 1'b1;
      state_next = ST_SETUP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pix_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pix_valid <= pix_valid_next;
    end
  end

endmodule

@@ design/lr_datapath.sv @@
// Datapath: endpoint setup, Bresenham stepping and the pixel output register.
module lr_datapath (
  input  logic            clk,
  input  lr_pkg::lr_cmd_t cmd,
  output lr_pkg::lr_status_t status,
  input  lr_pkg::coord_t  x_start,
  input  lr_pkg::coord_t  y_start,
  input  lr_pkg::coord_t  x_end,
  input  lr_pkg::coord_t  y_end,
  input  lr_pkg::color_t  color,
  output lr_pkg::coord_t  pixel_x,
  output lr_pkg::coord_t  pixel_y,
  output lr_pkg::color_t  pixel_color,
  output logic            last_pixel
);
  import lr_pkg::*;

  // Raw endpoints and steepness from the load beat
  coord_t ax, ay, bx, by;
  logic   steep;
  // Drawing state
  coord_t major_cursor, minor_cursor, major_limit;
  delta_t major_delta, minor_delta;
  err_t   error_term;
  logic   minor_step_negative, axes_swapped;
  color_t line_colour;

  // Setup combinational terms
  coord_t a_maj, a_min, b_maj, b_min;
  coord_t lo_maj, lo_min, hi_maj, hi_min;
  logic   swap_ends;
  err_t   maj_diff, min_diff;
  // Step combinational terms
  err_t   err_sub;

  assign status.last = major_cursor >= major_limit;

  // Swap axes for steep lines, then order so the major coordinate rises
  always_comb begin
    a_maj     = steep ? ay : ax;
    a_min     = steep ? ax : ay;
    b_maj     = steep ? by : bx;
    b_min     = steep ? bx : by;
    swap_ends = a_maj > b_maj;
    lo_maj    = swap_ends ? b_maj : a_maj;
    lo_min    = swap_ends ? b_min : a_min;
    hi_maj    = swap_ends ? a_maj : b_maj;
    hi_min    = swap_ends ? a_min : b_min;
    maj_diff  = ext(hi_maj) - ext(lo_maj);
    min_diff  = mag(ext(hi_min) - ext(lo_min));
  end

  assign err_sub = error_term - err_t'({1'b0, minor_delta});

  always_ff @(posedge clk) begin
    // load beat: latch endpoints, decide steepness
    if (cmd.load) begin
      ax          <= x_start;
      ay          <= y_start;
      bx          <= x_end;
      by          <= y_end;
      line_colour <= color;
      steep       <= mag(ext(y_end) - ext(y_start)) > mag(ext(x_end) - ext(x_start));
    end
    // setup cycle
    if (cmd.setup) begin
      major_cursor        <= lo_maj;
      minor_cursor        <= lo_min;
      major_limit         <= hi_maj;
      major_delta         <= maj_diff[COORD_BITS-1:0];
      minor_delta         <= min_diff[COORD_BITS-1:0];
      error_term          <= err_t'({2'b00, maj_diff[COORD_BITS-1:1]});
      minor_step_negative <= !(lo_min < hi_min);
      axes_swapped        <= steep;
    end
    // pixel step
    if (cmd.step) begin
      pixel_x     <= axes_swapped ? minor_cursor : major_cursor;
      pixel_y     <= axes_swapped ? major_cursor : minor_cursor;
      pixel_color <= line_colour;
      last_pixel  <= status.last;
      if (!status.last) begin
        major_cursor <= major_cursor + coord_t'(1);
        if (err_sub[ERR_BITS-1]) begin
          minor_cursor <= minor_step_negative ? minor_cursor - coord_t'(1)
                                              : minor_cursor + coord_t'(1);
          error_term   <= err_sub + err_t'({1'b0, major_delta});
        end else begin
          error_term   <= err_sub;
        end
      end
    end
  end

endmodule

@@ design/line_rasterizer.sv @@
// Top level of the Bresenham line rasterizer.
//
// Command channel (cmd_valid / cmd_stall) carries op, endpoints and colour.
// op = load latches a new line; op = step asks for the next pixel. A load
// emits nothing and replaces any line in progress. A step while no line is
// active is taken and dropped.
// Pixel channel (pix_valid / pix_stall) carries pixel_x, pixel_y,
// pixel_color and last_pixel; last_pixel marks the end of the line.
// A pixel beat is registered: it appears in the cycle after its step beat
// is taken. Throughput: one step beat per cycle while drawing and no pixel
// waits on a stalled receiver. After a load the command channel stalls in
// the setup state, where endpoints are swapped, ordered and deltas formed.
// A pixel held by a stalled receiver stalls the command channel, so no
// pixel is lost; the output register lets the next step be taken in the
// same cycle the waiting pixel is taken.
// Reset (rst, synchronous) returns the block to idle with no pixel pending.
module line_rasterizer (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  logic           op,
  input  lr_pkg::coord_t x_start,
  input  lr_pkg::coord_t y_start,
  input  lr_pkg::coord_t x_end,
  input  lr_pkg::coord_t y_end,
  input  lr_pkg::color_t color,
  output logic           pix_valid,
  input  logic           pix_stall,
  output lr_pkg::coord_t pixel_x,
  output lr_pkg::coord_t pixel_y,
  output lr_pkg::color_t pixel_color,
  output logic           last_pixel
);
  import lr_pkg::*;

  lr_cmd_t    cmd;
  lr_status_t status;

  // Sequencing and handshakes
  lr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .op        (op),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Arithmetic and pixel register
  lr_datapath u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .status      (status),
    .x_start     (x_start),
    .y_start     (y_start),
    .x_end       (x_end),
    .y_end       (y_end),
    .color       (color),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last_pixel  (last_pixel)
  );

endmodule
